// File: hw/rtl/mpn_pkg.sv
`timescale 1ns / 1ps
package mpn_pkg;
    localparam int MAX_HIDDEN_DEF  = 64;
    localparam int MAX_ROWS_DEF    = 512;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int ACC_W           = 25;
    localparam int ROWCNT_W        = 10;
    localparam logic [ROWCNT_W-1:0] ROW_COUNT_MAX = 10'd1023;

    // divider request/response
    typedef struct packed {
        logic        start;
        logic [39:0] dividend;
        logic [31:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [39:0] quotient;
    } div_rsp_t;
endpackage

// File: hw/rtl/mpn_divider.sv
`timescale 1ns / 1ps
module mpn_divider
    import mpn_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);
    // restoring divider, one quotient bit per cycle
    logic [39:0] quo_reg, quo_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] dvs_reg, dvs_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] trial;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[31:0], quo_reg[39]};
        if (req.start)
        begin
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
            cnt_next  = 6'd40;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = trial - {1'b0, dvs_reg};
                quo_next = {quo_reg[38:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[38:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;
endmodule

// File: hw/rtl/mean_pool_l2_normalize.sv
`timescale 1ns / 1ps
// Channel   | Direction | Ports
// ----------+-----------+------------------------------------------------------
// input     | in        | start, busy, sample, end_of_sequence
// result    | out       | result_valid, pooled_value, column_index, last_value,
//           |           | overflow_seen
// config    | in        | cfg_we, cfg_data (hidden_size)
//
// A plain element keeps busy high for one cycle (add and write back), so the
// block takes no new element until that write is done. A marked element then
// runs the normalize pass: max scan, up to 15 shift steps, square sum (one
// shared multiplier), 29-step square root, and per column a read, a setup, a
// 40-step divide and the result. Then the store is cleared.
// busy is high all that time. Reset clears the sums via that same clearing
// pass. Results cannot be stalled.
module mean_pool_l2_normalize
    import mpn_pkg::*;
#(
    parameter int MAX_HIDDEN  = MAX_HIDDEN_DEF,
    parameter int MAX_ROWS    = MAX_ROWS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  logic                   end_of_sequence,
    input  logic                   cfg_we,
    input  logic [6:0]             cfg_data,
    output logic                   result_valid,
    output logic [15:0]            pooled_value,
    output logic [5:0]             column_index,
    output logic                   last_value,
    output logic                   overflow_seen
);
    localparam int AW = (MAX_HIDDEN > 1) ? $clog2(MAX_HIDDEN) : 1;
    // add width: covers both the accumulator and the widest sample
    localparam int SUM_W = ((SAMPLE_BITS > ACC_W) ? SAMPLE_BITS : ACC_W) + 2;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_ADD   = 4'd2;
    localparam logic [3:0] S_MAXRD = 4'd3;
    localparam logic [3:0] S_MAX   = 4'd4;
    localparam logic [3:0] S_SQRD  = 4'd5;
    localparam logic [3:0] S_SQ    = 4'd6;
    localparam logic [3:0] S_SQRT  = 4'd7;
    localparam logic [3:0] S_DVRD  = 4'd8;
    localparam logic [3:0] S_DVGO  = 4'd9;
    localparam logic [3:0] S_DVW   = 4'd10;
    localparam logic [3:0] S_SHIFT = 4'd11;
    localparam logic [3:0] S_SQMUL = 4'd12;

    logic [3:0] state_reg, state_next;

    // column sums store
    logic signed [ACC_W-1:0] mem [MAX_HIDDEN];
    logic signed [ACC_W-1:0] rd_reg;
    logic [AW-1:0]           rd_addr;
    logic                    wr_en;
    logic [AW-1:0]           wr_addr;
    logic signed [ACC_W-1:0] wr_data;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_reg <= mem[rd_addr];
    end

    logic [6:0]  hsize_reg;
    logic [6:0]  h_act;
    logic [AW:0] pos_reg, pos_next;
    logic [ROWCNT_W-1:0] rows_reg, rows_next;
    logic        ovf_reg, ovf_next;
    logic        eos_reg, eos_next;
    logic signed [SAMPLE_BITS-1:0] smp_reg, smp_next;
    logic [AW:0] idx_reg, idx_next;
    logic [AW:0] col_use;

    logic [24:0] max_reg, max_next;
    logic [4:0]  rsh_reg, rsh_next;
    logic [4:0]  lsh_reg, lsh_next;
    logic [15:0] shm_reg, shm_next;
    logic [37:0] q_reg, q_next;
    logic [57:0] sq_x_reg, sq_x_next;
    logic [31:0] sq_r_reg, sq_r_next;
    logic [33:0] sq_rem_reg, sq_rem_next;
    logic [5:0]  sq_cnt_reg, sq_cnt_next;
    logic        negs_reg, negs_next;

    logic        vld_reg, vld_next;
    logic [15:0] pv_reg, pv_next;
    logic [5:0]  ci_reg, ci_next;
    logic        lv_reg, lv_next;
    logic        ov_reg, ov_next;

    div_req_t dreq;
    div_rsp_t drsp;

    mpn_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    always_comb
    begin
        h_act = hsize_reg;
        if (h_act == 7'd0)
            h_act = 7'd1;
        if (h_act > 7'(MAX_HIDDEN))
            h_act = 7'(MAX_HIDDEN);
    end

    logic [24:0] rd_mag;
    logic signed [SUM_W-1:0] sum_w;
    logic [33:0] sq_trial;
    logic [16:0] q_round;
    logic [31:0] sq_prod;

    assign rd_mag  = rd_reg[ACC_W-1] ? 25'(-rd_reg) : 25'(rd_reg);
    assign sum_w   = SUM_W'(rd_reg) + SUM_W'(smp_reg);
    assign col_use = ({1'b0, pos_reg} >= (AW+2)'(h_act)) ? '0 : pos_reg;
    assign sq_trial = {sq_rem_reg[31:0], sq_x_reg[57:56]} - {sq_r_reg, 2'b01};
    assign q_round = (|drsp.quotient[39:17]) ? 17'h1FFFF : drsp.quotient[16:0];
    assign sq_prod = shm_reg * shm_reg;

    always_comb
    begin
        state_next = state_reg;
        pos_next = pos_reg; rows_next = rows_reg; ovf_next = ovf_reg;
        eos_next = eos_reg; smp_next = smp_reg; idx_next = idx_reg;
        max_next = max_reg; rsh_next = rsh_reg; lsh_next = lsh_reg;
        shm_next = shm_reg; q_next = q_reg;
        sq_x_next = sq_x_reg; sq_r_next = sq_r_reg; sq_rem_next = sq_rem_reg;
        sq_cnt_next = sq_cnt_reg; negs_next = negs_reg;
        vld_next = 1'b0; pv_next = pv_reg; ci_next = ci_reg;
        lv_next = lv_reg; ov_next = ov_reg;
        rd_addr = idx_reg[AW-1:0];
        wr_en = 1'b0; wr_addr = idx_reg[AW-1:0]; wr_data = '0;
        dreq.start = 1'b0;
        // shifted magnitude below 2^15, so magnitude * 2^25 fits in 40 bits
        dreq.dividend = {shm_reg[14:0], 25'd0} + 40'(sq_r_reg[31:1]);
        dreq.divisor = sq_r_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                wr_en = 1'b1;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == (AW+1)'(MAX_HIDDEN - 1))
                begin
                    idx_next = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                rd_addr = col_use[AW-1:0];
                if (start)
                begin
                    idx_next = col_use;
                    smp_next = sample;
                    eos_next = end_of_sequence;
                    state_next = S_ADD;
                end
            end
            S_ADD:
            begin
                wr_en = 1'b1;
                if (rows_reg >= ROWCNT_W'(MAX_ROWS < 1023 ? MAX_ROWS : 1023)
                    && MAX_ROWS <= 1023)
                    ovf_next = 1'b1;
                if (sum_w > SUM_W'(16777215))
                begin
                    wr_data = 25'(16777215); ovf_next = 1'b1;
                end
                else if (sum_w < -SUM_W'(16777216))
                begin
                    wr_data = 25'h1000000; ovf_next = 1'b1;
                end
                else
                    wr_data = 25'(sum_w);
                if ((idx_reg + 1'b1) >= (AW+1)'(h_act))
                begin
                    pos_next = '0;
                    if (rows_reg != ROW_COUNT_MAX)
                        rows_next = rows_reg + 1'b1;
                end
                else
                    pos_next = idx_reg + 1'b1;
                if (eos_reg)
                begin
                    idx_next = '0; max_next = '0;
                    state_next = S_MAXRD;
                end
                else
                    state_next = S_IDLE;
            end
            S_MAXRD:
            begin
                idx_next = idx_reg + 1'b1;
                state_next = S_MAX;
            end
            S_MAX:
            begin
                if (rd_mag > max_reg)
                    max_next = rd_mag;
                if (idx_reg >= (AW+1)'(h_act))
                begin
                    idx_next = '0; rsh_next = '0; lsh_next = '0;
                    state_next = S_SHIFT;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    state_next = S_MAX;
                end
            end
            S_SHIFT:
            begin
                // one shift step per cycle toward [2^14, 2^15)
                if (max_reg == '0)
                begin
                    sq_r_next = '0; idx_next = '0;
                    state_next = S_DVRD;
                end
                else if ((max_reg >> rsh_reg) >= 25'd32768)
                    rsh_next = rsh_reg + 1'b1;
                else if (((max_reg >> rsh_reg) << lsh_reg) < 25'd16384)
                    lsh_next = lsh_reg + 1'b1;
                else
                begin
                    q_next = '0; idx_next = '0;
                    state_next = S_SQRD;
                end
            end
            S_SQRD:
            begin
                idx_next = idx_reg + 1'b1;
                state_next = S_SQMUL;
            end
            S_SQMUL:
            begin
                // shared multiplier: square of shifted magnitude
                shm_next = 16'((rd_mag >> rsh_reg) << lsh_reg);
                state_next = S_SQ;
            end
            S_SQ:
            begin
                q_next = q_reg + 38'(sq_prod);
                if (idx_reg >= (AW+1)'(h_act))
                begin
                    sq_x_next = {q_reg + 38'(sq_prod), 20'd0};
                    sq_r_next = '0; sq_rem_next = '0; sq_cnt_next = 6'd29;
                    state_next = S_SQRT;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    state_next = S_SQMUL;
                end
            end
            S_SQRT:
            begin
                // digit-by-digit root, one result bit per cycle
                if (!sq_trial[33])
                begin
                    sq_rem_next = sq_trial;
                    sq_r_next = {sq_r_reg[30:0], 1'b1};
                end
                else
                begin
                    sq_rem_next = {sq_rem_reg[31:0], sq_x_reg[57:56]};
                    sq_r_next = {sq_r_reg[30:0], 1'b0};
                end
                sq_x_next = {sq_x_reg[55:0], 2'b00};
                sq_cnt_next = sq_cnt_reg - 1'b1;
                if (sq_cnt_reg == 6'd1)
                begin
                    idx_next = '0;
                    state_next = S_DVRD;
                end
            end
            S_DVRD:
            begin
                state_next = S_DVGO;
            end
            S_DVGO:
            begin
                shm_next = 16'((rd_mag >> rsh_reg) << lsh_reg);
                negs_next = rd_reg[ACC_W-1];
                if (sq_r_reg == '0)
                begin
                    q_next = '0;
                    state_next = S_DVW;
                end
                else
                begin
                    state_next = S_DVW;
                    q_next = 38'h3FFFFFFFFF;
                end
            end
            S_DVW:
            begin
                if (q_reg == 38'h3FFFFFFFFF)
                begin
                    dreq.start = 1'b1;
                    q_next = 38'h3FFFFFFFFE;
                end
                else if (q_reg == '0 || drsp.done)
                begin
                    vld_next = 1'b1;
                    ci_next = 6'(idx_reg);
                    lv_next = ((idx_reg + 1'b1) == (AW+1)'(h_act));
                    ov_next = ovf_reg;
                    if (q_reg == '0)
                        pv_next = '0;
                    else if (negs_reg)
                        pv_next = (q_round > 17'd32768) ? 16'h8000 : 16'(-q_round);
                    else
                        pv_next = (q_round > 17'd32767) ? 16'h7FFF : q_round[15:0];
                    if (lv_next)
                    begin
                        idx_next = '0; pos_next = '0; rows_next = '0;
                        ovf_next = 1'b0;
                        state_next = S_CLEAR;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                        state_next = S_DVRD;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            hsize_reg <= 7'd64;
            pos_reg <= '0; rows_reg <= '0; ovf_reg <= 1'b0;
            idx_reg <= '0; vld_reg <= 1'b0; q_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                hsize_reg <= cfg_data;
            pos_reg <= pos_next; rows_reg <= rows_next; ovf_reg <= ovf_next;
            idx_reg <= idx_next; vld_reg <= vld_next; q_reg <= q_next;
        end
    end

    always_ff @(posedge clk)
    begin
        eos_reg <= eos_next; smp_reg <= smp_next;
        max_reg <= max_next; rsh_reg <= rsh_next; lsh_reg <= lsh_next;
        shm_reg <= shm_next;
        sq_x_reg <= sq_x_next; sq_r_reg <= sq_r_next; sq_rem_reg <= sq_rem_next;
        sq_cnt_reg <= sq_cnt_next; negs_reg <= negs_next;
        pv_reg <= pv_next; ci_reg <= ci_next; lv_reg <= lv_next; ov_reg <= ov_next;
    end

    assign busy          = (state_reg != S_IDLE);
    assign result_valid  = vld_reg;
    assign pooled_value  = pv_reg;
    assign column_index  = ci_reg;
    assign last_value    = lv_reg;
    assign overflow_seen = ov_reg;

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> busy || $past(state_reg) == S_DVW)
        else $error("result outside normalize pass");
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= (AW+1)'(MAX_HIDDEN))
        else $error("column position out of range");
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && last_value) |-> state_reg == S_CLEAR)
        else $error("no clear after last transfer");
endmodule

// File: dv/mpn_checker.sv
`timescale 1ns / 1ps
module mpn_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [15:0] sample,
    input  logic        end_of_sequence,
    input  logic        cfg_we,
    input  logic [6:0]  cfg_data,
    input  logic        result_valid,
    input  logic [15:0] pooled_value,
    input  logic [5:0]  column_index,
    input  logic        last_value,
    input  logic        overflow_seen,
    output int          errors,
    output int          pending
);
    localparam longint SUM_MAX  = 64'sd16777215;
    localparam longint SUM_MIN  = -64'sd16777216;
    localparam int     ROW_CAP  = 512;
    localparam int     ROW_SAT  = 1023;

    typedef struct {
        logic [15:0] value;
        logic [5:0]  col;
        logic        last;
        logic        ovf;
    } pooled_t;

    pooled_t     pooled_q[$];
    longint      col_sum[64];
    int          col_pos;
    int          rows_done;
    logic        ovf_flag;
    logic [6:0]  hidden_reg;

    task automatic report(input string what);
        $display("%0t mismatch: %s", $realtime, what);
        errors++;
    endtask

    function automatic logic [63:0] int_sqrt(input logic [63:0] x);
        logic [63:0] root;
        logic [63:0] bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv >>= 2;
        while (bitv != 0)
        begin
            if (x >= root + bitv)
            begin
                x    = x - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv >>= 2;
        end
        return root;
    endfunction

    function automatic int active_width();
        if (hidden_reg == 0) return 1;
        if (hidden_reg > 64) return 64;
        return hidden_reg;
    endfunction

    function automatic void clear_sums();
        foreach (col_sum[i]) col_sum[i] = 0;
        col_pos   = 0;
        rows_done = 0;
        ovf_flag  = 0;
    endfunction

    // normalize the column sums and queue one result per column
    function automatic void close_vector(input int h);
        logic [63:0] mag[64];
        logic [63:0] peak, sq_sum, norm, q;
        int          rsh, lsh;
        pooled_t     r;
        peak = 0; sq_sum = 0; norm = 0; rsh = 0; lsh = 0;
        for (int i = 0; i < h; i++)
        begin
            mag[i] = (col_sum[i] < 0) ? -col_sum[i] : col_sum[i];
            if (mag[i] > peak) peak = mag[i];
        end
        if (peak != 0)
        begin
            while ((peak >> rsh) >= 32768) rsh++;
            while (((peak >> rsh) << lsh) < 16384) lsh++;
            for (int i = 0; i < h; i++)
            begin
                mag[i] = (mag[i] >> rsh) << lsh;
                sq_sum += mag[i] * mag[i];
            end
            norm = int_sqrt(sq_sum << 20);
        end
        for (int i = 0; i < h; i++)
        begin
            q = 0;
            if (norm != 0) q = ((mag[i] << 25) + norm / 2) / norm;
            if (col_sum[i] < 0)
            begin
                if (q > 32768) q = 32768;
                r.value = 16'(-q);
            end
            else
            begin
                if (q > 32767) q = 32767;
                r.value = q[15:0];
            end
            r.col  = 6'(i);
            r.last = (i + 1 == h);
            r.ovf  = ovf_flag;
            pooled_q.insert(pooled_q.size(), r);
        end
    endfunction

    function automatic void accumulate(input logic signed [15:0] s, input logic eos);
        int     h, col;
        longint acc;
        h   = active_width();
        col = col_pos;
        if (col >= h) col = 0;  // stale position after a width change
        if (rows_done >= ROW_CAP) ovf_flag = 1;
        acc = col_sum[col] + longint'(s);
        if (acc > SUM_MAX)
        begin
            acc = SUM_MAX; ovf_flag = 1;
        end
        else if (acc < SUM_MIN)
        begin
            acc = SUM_MIN; ovf_flag = 1;
        end
        col_sum[col] = acc;
        if (col + 1 >= h)
        begin
            col_pos = 0;
            if (rows_done < ROW_SAT) rows_done++;
        end
        else
            col_pos = col + 1;
        if (eos)
        begin
            close_vector(h);
            clear_sums();
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pooled_t e;
        if (!rst_n)
        begin
            clear_sums();
            hidden_reg = 7'd64;
            pooled_q.delete();
        end
        else
        begin
            // results first: a result can never stem from a transfer at this same edge
            if (result_valid)
            begin
                if (pooled_q.size() == 0)
                    report($sformatf("unexpected result col %0d", column_index));
                else
                begin
                    e = pooled_q.pop_front();
                    if (pooled_value !== e.value)
                        report($sformatf("col %0d value %h, want %h",
                                         e.col, pooled_value, e.value));
                    if (column_index !== e.col)
                        report($sformatf("column_index %0d, want %0d",
                                         column_index, e.col));
                    if (last_value !== e.last)
                        report($sformatf("col %0d last_value %b, want %b",
                                         e.col, last_value, e.last));
                    if (overflow_seen !== e.ovf)
                        report($sformatf("col %0d overflow_seen %b, want %b",
                                         e.col, overflow_seen, e.ovf));
                end
            end
            if (cfg_we) hidden_reg = cfg_data;
            if (start && !busy) accumulate(sample, end_of_sequence);
        end
        pending = pooled_q.size();
    end
endmodule

// File: dv/mean_pool_l2_normalize_tb.sv
`timescale 1ns / 1ps
module mean_pool_l2_normalize_tb;
    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [15:0] sample;
    logic        end_of_sequence;
    logic        cfg_we;
    logic [6:0]  cfg_data;
    logic        result_valid;
    logic [15:0] pooled_value;
    logic [5:0]  column_index;
    logic        last_value;
    logic        overflow_seen;
    int          errors;
    int          pending;

    int          sent;      // element transfers in the random part
    logic        allow_gaps;

    mean_pool_l2_normalize u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .sample          (sample),
        .end_of_sequence (end_of_sequence),
        .cfg_we          (cfg_we),
        .cfg_data        (cfg_data),
        .result_valid    (result_valid),
        .pooled_value    (pooled_value),
        .column_index    (column_index),
        .last_value      (last_value),
        .overflow_seen   (overflow_seen)
    );

    // checker sits beside the block: predicts on every transfer, compares results
    mpn_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .sample          (sample),
        .end_of_sequence (end_of_sequence),
        .cfg_we          (cfg_we),
        .cfg_data        (cfg_data),
        .result_valid    (result_valid),
        .pooled_value    (pooled_value),
        .column_index    (column_index),
        .last_value      (last_value),
        .overflow_seen   (overflow_seen),
        .errors          (errors),
        .pending         (pending)
    );

    always
    begin
        clk = 1'b0; #5;
        clk = 1'b1; #5;
    end

    // one element transfer; called and returns at a falling edge
    task automatic send_element(input logic [15:0] s, input logic eos);
        start           <= 1'b1;
        sample          <= s;
        end_of_sequence <= eos;
        do @(posedge clk); while (busy);
        @(negedge clk);
        // random idle burst on the sender side
        if (allow_gaps && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
    endtask

    // drain: stop sending, wait for every expected result, then let the
    // clearing pass that follows a vector finish before touching the register
    task automatic drain();
        start <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (80) @(negedge clk);
        while (busy) @(negedge clk);
    endtask

    task automatic set_width(input logic [6:0] w);
        drain();
        cfg_we   <= 1'b1;
        cfg_data <= w;
        @(negedge clk);
        cfg_we   <= 1'b0;
        @(negedge clk);
    endtask

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 5))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'(int'($urandom_range(0, 15)) - 8);
            default: return 16'($urandom);
        endcase
    endfunction

    // rows of random content; last element marked
    task automatic send_vector(input int n);
        for (int i = 0; i < n; i++)
        begin
            send_element(pick_sample(), i == n - 1);
            sent++;
        end
    endtask

    initial
    begin
        int h, n;
        rst_n           = 1'b0;
        start           = 1'b0;
        sample          = '0;
        end_of_sequence = 1'b0;
        cfg_we          = 1'b0;
        cfg_data        = 7'd64;
        allow_gaps      = 1'b0;
        sent            = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // extremes at width 4, reset width first (one partial row of 64)
        send_element(16'h7FFF, 1'b1);
        set_width(7'd4);
        send_element(16'h7FFF, 1'b0);
        send_element(16'h8000, 1'b0);
        send_element(16'h0000, 1'b0);
        send_element(16'h0001, 1'b0);
        send_element(16'h7FFF, 1'b0);
        send_element(16'h8000, 1'b0);
        send_element(16'hFFFF, 1'b0);
        send_element(16'h0000, 1'b1);
        // all-zero sums give zero outputs
        repeat (3) send_element(16'h0000, 1'b0);
        send_element(16'h0000, 1'b1);
        // partial final row
        set_width(7'd8);
        send_element(16'h0100, 1'b0);
        send_element(16'hFF00, 1'b0);
        send_element(16'h0003, 1'b1);
        // stale column position: five columns in, width drops to three
        repeat (5) send_element(16'h1234, 1'b0);
        set_width(7'd3);
        send_element(16'h4321, 1'b0);
        send_element(16'hC000, 1'b1);
        // width 0 acts as 1, width 127 acts as 64
        set_width(7'd0);
        send_element(16'h8001, 1'b0);
        send_element(16'h0002, 1'b1);
        set_width(7'd127);
        send_element(16'h7FFF, 1'b1);

        // random part
        allow_gaps = 1'b1;
        while (sent < 72)
        begin
            if (sent > 55) allow_gaps = 1'b0;  // closing stretch runs back to back
            case ($urandom_range(0, 7))
                0: h = 64;
                1: h = $urandom_range(65, 127);
                2: h = 0;
                default: h = $urandom_range(1, 12);
            endcase
            set_width(7'(h));
            if (h == 0) h = 1;
            if (h > 64) h = 64;
            if ($urandom_range(0, 4) != 0)
                n = (h >= 32) ? h : h * $urandom_range(1, 3);
            else
                n = $urandom_range(1, (h >= 32) ? h : 3 * h);
            if (n > 80 - sent) n = 80 - sent;
            send_vector(n);
            // now and then (one pass in four) the sender holds off until the whole vector is back
            if ($urandom_range(0, 3) == 0)
            begin
                start <= 1'b0;
                while (pending != 0) @(negedge clk);
            end
        end

        start <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (200) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // watchdog
    initial
    begin
        #20ms;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule
